/* rtl/core/gn3d_pkg.sv */
// gn3d_pkg: shared constants, sequencer step map and command struct for the
// 3d gradient noise unit. No dependencies.
package gn3d_pkg;

  localparam int FRAC_BITS  = 16;
  localparam int TABLE_SIZE = 256;
  localparam int IDX_W      = $clog2(TABLE_SIZE);
  localparam int COORD_W    = 32;
  localparam int VAL_W      = 32;   // internal fixed point values
  localparam int OPW        = 26;   // multiplier operand width
  localparam int OUT_W      = 20;
  localparam int HALF_LSB   = 1 << (FRAC_BITS - 1);

  localparam logic signed [VAL_W-1:0] ONE         = VAL_W'(1 << FRAC_BITS);
  localparam logic signed [VAL_W-1:0] TEN_ONE     = VAL_W'(10 << FRAC_BITS);
  localparam logic signed [VAL_W-1:0] FIFTEEN_ONE = VAL_W'(15 << FRAC_BITS);
  localparam logic signed [VAL_W-1:0] OUT_MAX     = VAL_W'(524287);
  localparam logic signed [VAL_W-1:0] OUT_MIN     = -VAL_W'(524288);

  // hash walk levels
  localparam logic [1:0] LVL_X = 2'd0;
  localparam logic [1:0] LVL_Y = 2'd1;
  localparam logic [1:0] LVL_Z = 2'd2;
  localparam logic [2:0] LAST_CORNER = 3'd7;

  // fade phase step map (runs beside the hash walk)
  localparam logic [4:0] S_T2  = 5'd0;
  localparam logic [4:0] S_T3  = 5'd3;
  localparam logic [4:0] S_Q   = 5'd6;
  localparam logic [4:0] S_P   = 5'd9;
  localparam logic [4:0] S_U   = 5'd12;
  localparam logic [4:0] S_DU  = 5'd15;
  localparam logic [4:0] S_UV  = 5'd18;
  localparam logic [4:0] S_UW  = 5'd19;
  localparam logic [4:0] S_VW  = 5'd20;
  localparam logic [4:0] S_UVW = 5'd21;
  localparam logic [4:0] P1_LAST = 5'd22;

  // blend phase step map
  localparam logic [4:0] S_N   = 5'd0;
  localparam logic [4:0] S_GX  = 5'd7;
  localparam logic [4:0] S_GY  = 5'd10;
  localparam logic [4:0] S_GZ  = 5'd13;
  localparam logic [4:0] S_DX  = 5'd16;
  localparam logic [4:0] S_DY  = 5'd17;
  localparam logic [4:0] S_DZ  = 5'd18;
  localparam logic [4:0] P2_LAST = 5'd19;

  typedef struct packed {
    logic       start;       // evaluate transaction taken, capture point
    logic       load_wr;     // load transaction taken, write table
    logic       hash_issue;
    logic [2:0] crn;
    logic [1:0] lvl;
    logic       mul_en;
    logic       blend;       // 0 fade phase, 1 blend phase
    logic [4:0] step;
    logic       kcalc;
    logic       out_load;
  } gn3d_cmd_t;

endpackage

/* rtl/core/gn3d_ctrl.sv */
// gn3d_ctrl: sequencer for the 3d gradient noise unit.
// Depends on gn3d_pkg.
module gn3d_ctrl import gn3d_pkg::*; (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_valid,
  input  logic      in_action,
  output logic      in_ready,
  output logic      out_valid,
  input  logic      out_ready,
  output gn3d_cmd_t cmd
);

  typedef enum logic [2:0] {
    ST_IDLE, ST_FADE, ST_KCALC, ST_BLEND, ST_FINISH
  } state_t;

  state_t     state_r, state_nxt;
  logic [2:0] crn_r, crn_nxt;
  logic [1:0] lvl_r, lvl_nxt;
  logic       hbusy_r, hbusy_nxt;
  logic [4:0] mstep_r, mstep_nxt;
  logic       out_valid_r, out_valid_nxt;
  logic       accept;

  assign in_ready  = (state_r == ST_IDLE);
  assign out_valid = out_valid_r;
  assign accept    = in_valid && in_ready;

  always_comb begin
    cmd            = '0;
    cmd.start      = accept && in_action;
    cmd.load_wr    = accept && !in_action;
    cmd.hash_issue = (state_r == ST_FADE) && hbusy_r;
    cmd.crn        = crn_r;
    cmd.lvl        = lvl_r;
    cmd.mul_en     = ((state_r == ST_FADE) && (mstep_r < P1_LAST)) ||
                     ((state_r == ST_BLEND) && (mstep_r < P2_LAST));
    cmd.blend      = (state_r == ST_BLEND);
    cmd.step       = mstep_r;
    cmd.kcalc      = (state_r == ST_KCALC);
    cmd.out_load   = (state_r == ST_FINISH) && (!out_valid_r || out_ready);
  end

  always_comb begin
    state_nxt = state_r;
    crn_nxt   = crn_r;
    lvl_nxt   = lvl_r;
    hbusy_nxt = hbusy_r;
    mstep_nxt = mstep_r;
    unique case (state_r)
      ST_IDLE: begin
        if (cmd.start) begin
          state_nxt = ST_FADE;
          crn_nxt   = '0;
          lvl_nxt   = LVL_X;
          hbusy_nxt = 1'b1;
          mstep_nxt = '0;
        end
      end
      ST_FADE: begin
        if (hbusy_r) begin
          if (lvl_r == LVL_Z) begin
            lvl_nxt = LVL_X;
            crn_nxt = crn_r + 3'd1;
            if (crn_r == LAST_CORNER) hbusy_nxt = 1'b0;
          end else begin
            lvl_nxt = lvl_r + 2'd1;
          end
        end
        if (mstep_r < P1_LAST) mstep_nxt = mstep_r + 5'd1;
        if (!hbusy_r && (mstep_r == P1_LAST)) state_nxt = ST_KCALC;
      end
      ST_KCALC: begin
        state_nxt = ST_BLEND;
        mstep_nxt = '0;
      end
      ST_BLEND: begin
        if (mstep_r == P2_LAST) state_nxt = ST_FINISH;
        else mstep_nxt = mstep_r + 5'd1;
      end
      ST_FINISH: begin
        if (cmd.out_load) state_nxt = ST_IDLE;
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (out_valid_r && out_ready) out_valid_nxt = 1'b0;
    if (cmd.out_load) out_valid_nxt = 1'b1;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      crn_r       <= '0;
      lvl_r       <= LVL_X;
      hbusy_r     <= 1'b0;
      mstep_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      crn_r       <= crn_nxt;
      lvl_r       <= lvl_nxt;
      hbusy_r     <= hbusy_nxt;
      mstep_r     <= mstep_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

endmodule

/* rtl/core/gn3d_dp.sv */
// gn3d_dp: datapath of the 3d gradient noise unit: permutation memory,
// corner dot products, shared rounding multiplier and result registers.
// Depends on gn3d_pkg.
module gn3d_dp import gn3d_pkg::*; (
  input  logic                      clk,
  input  logic                      rst_n,
  input  gn3d_cmd_t                 cmd,
  input  logic [IDX_W-1:0]          in_table_index,
  input  logic [7:0]                in_table_value,
  input  logic signed [COORD_W-1:0] in_coord_x,
  input  logic signed [COORD_W-1:0] in_coord_y,
  input  logic signed [COORD_W-1:0] in_coord_z,
  output logic signed [OUT_W-1:0]   out_noise_value,
  output logic signed [OUT_W-1:0]   out_deriv_x,
  output logic signed [OUT_W-1:0]   out_deriv_y,
  output logic signed [OUT_W-1:0]   out_deriv_z
);

  typedef enum logic [4:0] {
    G_NONE, G_T2, G_T3, G_Q, G_P, G_U, G_DU, G_UV, G_UW, G_VW, G_UVW,
    G_N, G_GX, G_GY, G_GZ, G_DX, G_DY, G_DZ
  } grp_t;

  typedef struct packed {
    grp_t       grp;
    logic [2:0] sub;
  } op_t;

  typedef logic signed [VAL_W-1:0] val_t;

  logic [7:0]       perm_mem [TABLE_SIZE];
  logic [7:0]       rd_data_r;
  logic [IDX_W-1:0] hash_addr;
  logic [IDX_W-1:0] cell_r [3];
  val_t             t_r [3];
  logic             issue_q_r;
  logic [2:0]       crn_q_r;
  logic [1:0]       lvl_q_r;
  val_t             dot_r [8];
  val_t             k_r [7];
  val_t             t2_r [3], t3_r [3], q_r [3], p_r [3], f_r [3], dd_r [3];
  val_t             uv_r, uw_r, vw_r, uvw_r;
  val_t             accn_r, accx_r, accy_r, accz_r, gx_r, gy_r, gz_r;
  val_t             prod_r;
  logic             wb_en_r;
  op_t              wb_op_r;
  op_t              cur;
  logic [1:0]       ax;
  val_t             sel_a, sel_b, wsel;
  logic signed [OPW-1:0]   mul_a, mul_b;
  logic signed [2*OPW-1:0] prod_full;
  logic signed [2*OPW:0]   rnd;
  val_t             ox, oy, oz, dot_new;

  function automatic val_t grad_dot(input logic [3:0] g, input val_t x, input val_t y,
                                    input val_t z);
    val_t r;
    case (g)
      4'd0:    r = x + y;
      4'd1:    r = -x + y;
      4'd2:    r = x - y;
      4'd3:    r = -x - y;
      4'd4:    r = x + z;
      4'd5:    r = -x + z;
      4'd6:    r = x - z;
      4'd7:    r = -x - z;
      4'd8:    r = y + z;
      4'd9:    r = -y + z;
      4'd10:   r = y - z;
      4'd11:   r = -y - z;
      4'd12:   r = y + x;
      4'd13:   r = -x + y;
      4'd14:   r = -y + z;
      default: r = -y - z;
    endcase
    return r;
  endfunction

  function automatic op_t decode(input logic blend, input logic [4:0] s);
    op_t        o;
    logic [4:0] d;
    o.grp = G_NONE;
    d     = s;
    if (!blend) begin
      if (s < S_T3)        begin o.grp = G_T2;  d = s - S_T2; end
      else if (s < S_Q)    begin o.grp = G_T3;  d = s - S_T3; end
      else if (s < S_P)    begin o.grp = G_Q;   d = s - S_Q;  end
      else if (s < S_U)    begin o.grp = G_P;   d = s - S_P;  end
      else if (s < S_DU)   begin o.grp = G_U;   d = s - S_U;  end
      else if (s < S_UV)   begin o.grp = G_DU;  d = s - S_DU; end
      else if (s == S_UV)  o.grp = G_UV;
      else if (s == S_UW)  o.grp = G_UW;
      else if (s == S_VW)  o.grp = G_VW;
      else if (s == S_UVW) o.grp = G_UVW;
    end else begin
      if (s < S_GX)        begin o.grp = G_N;   d = s - S_N;  end
      else if (s < S_GY)   begin o.grp = G_GX;  d = s - S_GX; end
      else if (s < S_GZ)   begin o.grp = G_GY;  d = s - S_GY; end
      else if (s < S_DX)   begin o.grp = G_GZ;  d = s - S_GZ; end
      else if (s == S_DX)  o.grp = G_DX;
      else if (s == S_DY)  o.grp = G_DY;
      else if (s == S_DZ)  o.grp = G_DZ;
    end
    o.sub = d[2:0];
    return o;
  endfunction

  function automatic logic signed [OUT_W-1:0] sat(input val_t v);
    val_t r;
    r = v;
    if (v > OUT_MAX) r = OUT_MAX;
    if (v < OUT_MIN) r = OUT_MIN;
    return r[OUT_W-1:0];
  endfunction

  // permutation walk address
  always_comb begin
    unique case (cmd.lvl)
      LVL_X:   hash_addr = cell_r[0] + IDX_W'(cmd.crn[0]);
      LVL_Y:   hash_addr = rd_data_r + cell_r[1] + IDX_W'(cmd.crn[1]);
      default: hash_addr = rd_data_r + cell_r[2] + IDX_W'(cmd.crn[2]);
    endcase
  end

  always_ff @(posedge clk) begin
    if (cmd.load_wr) perm_mem[in_table_index] <= in_table_value;
    if (cmd.hash_issue) rd_data_r <= perm_mem[hash_addr];
  end

  // corner offsets and dot product of the finished hash
  assign ox      = crn_q_r[0] ? t_r[0] - ONE : t_r[0];
  assign oy      = crn_q_r[1] ? t_r[1] - ONE : t_r[1];
  assign oz      = crn_q_r[2] ? t_r[2] - ONE : t_r[2];
  assign dot_new = grad_dot(rd_data_r[3:0], ox, oy, oz);

  // operand select
  assign cur = cmd.mul_en ? decode(cmd.blend, cmd.step) : op_t'{grp: G_NONE, sub: 3'd0};
  assign ax  = cur.sub[1:0];

  always_comb begin
    case (cur.sub)
      3'd0:    wsel = f_r[0];
      3'd1:    wsel = f_r[1];
      3'd2:    wsel = f_r[2];
      3'd3:    wsel = uv_r;
      3'd4:    wsel = uw_r;
      3'd5:    wsel = vw_r;
      default: wsel = uvw_r;
    endcase
  end

  always_comb begin
    sel_a = '0;
    sel_b = '0;
    case (cur.grp)
      G_T2:  begin sel_a = t_r[ax];  sel_b = t_r[ax]; end
      G_T3:  begin sel_a = t2_r[ax]; sel_b = t_r[ax]; end
      G_Q:   begin sel_a = t_r[ax];  sel_b = (t_r[ax] <<< 2) + (t_r[ax] <<< 1) - FIFTEEN_ONE; end
      G_P:   begin sel_a = t_r[ax];  sel_b = t_r[ax] - ONE; end
      G_U:   begin sel_a = t3_r[ax]; sel_b = q_r[ax]; end
      G_DU:  begin sel_a = p_r[ax];  sel_b = p_r[ax]; end
      G_UV:  begin sel_a = f_r[0];   sel_b = f_r[1]; end
      G_UW:  begin sel_a = f_r[0];   sel_b = f_r[2]; end
      G_VW:  begin sel_a = f_r[1];   sel_b = f_r[2]; end
      G_UVW: begin sel_a = uv_r;     sel_b = f_r[2]; end
      G_N:   begin sel_a = k_r[cur.sub]; sel_b = wsel; end
      G_GX: begin
        case (cur.sub)
          3'd0:    begin sel_a = k_r[3]; sel_b = f_r[1]; end
          3'd1:    begin sel_a = k_r[4]; sel_b = f_r[2]; end
          default: begin sel_a = k_r[6]; sel_b = vw_r;   end
        endcase
      end
      G_GY: begin
        case (cur.sub)
          3'd0:    begin sel_a = k_r[3]; sel_b = f_r[0]; end
          3'd1:    begin sel_a = k_r[5]; sel_b = f_r[2]; end
          default: begin sel_a = k_r[6]; sel_b = uw_r;   end
        endcase
      end
      G_GZ: begin
        case (cur.sub)
          3'd0:    begin sel_a = k_r[4]; sel_b = f_r[0]; end
          3'd1:    begin sel_a = k_r[5]; sel_b = f_r[1]; end
          default: begin sel_a = k_r[6]; sel_b = uv_r;   end
        endcase
      end
      G_DX:  begin sel_a = dd_r[0]; sel_b = accx_r; end
      G_DY:  begin sel_a = dd_r[1]; sel_b = accy_r; end
      G_DZ:  begin sel_a = dd_r[2]; sel_b = accz_r; end
      default: begin sel_a = '0; sel_b = '0; end
    endcase
  end

  // shared multiplier, round half up then drop the fraction bits
  assign mul_a     = sel_a[OPW-1:0];
  assign mul_b     = sel_b[OPW-1:0];
  assign prod_full = mul_a * mul_b;
  assign rnd       = (2*OPW+1)'(prod_full) + (2*OPW+1)'(HALF_LSB);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      issue_q_r <= 1'b0;
      wb_en_r   <= 1'b0;
    end else begin
      issue_q_r <= cmd.hash_issue;
      wb_en_r   <= cmd.mul_en;
    end
  end

  always_ff @(posedge clk) begin
    crn_q_r <= cmd.crn;
    lvl_q_r <= cmd.lvl;
    wb_op_r <= cur;
    prod_r  <= rnd[FRAC_BITS +: VAL_W];

    if (cmd.start) begin
      cell_r[0] <= in_coord_x[FRAC_BITS +: IDX_W];
      cell_r[1] <= in_coord_y[FRAC_BITS +: IDX_W];
      cell_r[2] <= in_coord_z[FRAC_BITS +: IDX_W];
      t_r[0]    <= VAL_W'(in_coord_x[FRAC_BITS-1:0]);
      t_r[1]    <= VAL_W'(in_coord_y[FRAC_BITS-1:0]);
      t_r[2]    <= VAL_W'(in_coord_z[FRAC_BITS-1:0]);
    end

    if (issue_q_r && (lvl_q_r == LVL_Z)) dot_r[crn_q_r] <= dot_new;

    if (cmd.kcalc) begin
      k_r[0] <= dot_r[1] - dot_r[0];
      k_r[1] <= dot_r[2] - dot_r[0];
      k_r[2] <= dot_r[4] - dot_r[0];
      k_r[3] <= dot_r[0] + dot_r[3] - dot_r[1] - dot_r[2];
      k_r[4] <= dot_r[0] + dot_r[5] - dot_r[1] - dot_r[4];
      k_r[5] <= dot_r[0] + dot_r[6] - dot_r[2] - dot_r[4];
      k_r[6] <= dot_r[1] + dot_r[2] + dot_r[4] + dot_r[7]
              - dot_r[0] - dot_r[3] - dot_r[5] - dot_r[6];
      accn_r <= dot_r[0];
      accx_r <= dot_r[1] - dot_r[0];
      accy_r <= dot_r[2] - dot_r[0];
      accz_r <= dot_r[4] - dot_r[0];
    end

    // writeback of the registered product into the register its step selects
    if (wb_en_r) begin
      case (wb_op_r.grp)
        G_T2:  t2_r[wb_op_r.sub[1:0]] <= prod_r;
        G_T3:  t3_r[wb_op_r.sub[1:0]] <= prod_r;
        G_Q:   q_r[wb_op_r.sub[1:0]]  <= prod_r + TEN_ONE;
        G_P:   p_r[wb_op_r.sub[1:0]]  <= prod_r;
        G_U:   f_r[wb_op_r.sub[1:0]]  <= prod_r;
        G_DU:  dd_r[wb_op_r.sub[1:0]] <= (prod_r <<< 5) - (prod_r <<< 1);
        G_UV:  uv_r   <= prod_r;
        G_UW:  uw_r   <= prod_r;
        G_VW:  vw_r   <= prod_r;
        G_UVW: uvw_r  <= prod_r;
        G_N:   accn_r <= accn_r + prod_r;
        G_GX:  accx_r <= accx_r + prod_r;
        G_GY:  accy_r <= accy_r + prod_r;
        G_GZ:  accz_r <= accz_r + prod_r;
        G_DX:  gx_r   <= prod_r;
        G_DY:  gy_r   <= prod_r;
        G_DZ:  gz_r   <= prod_r;
        default: ;
      endcase
    end

    if (cmd.out_load) begin
      out_noise_value <= sat(accn_r);
      out_deriv_x     <= sat(gx_r);
      out_deriv_y     <= sat(gy_r);
      out_deriv_z     <= sat(gz_r);
    end
  end

endmodule

/* rtl/core/gradient_noise_3d_with_derivatives_unit.sv */
// channel  | direction | handshake             | payload
// in       | input     | in_valid / in_ready   | action, table index/value, point x y z
// out      | output    | out_valid / out_ready | noise value, x y z derivatives
//
// top level of the 3d gradient noise unit with analytic derivatives
// depends on gn3d_pkg, gn3d_ctrl, gn3d_dp
//
// a load transaction writes one permutation byte in its accept cycle
// an evaluate transaction shows its result after the hash walk (24 chained table reads,
// one per cycle through the registered read port) overlapped with the fade polynomials,
// a corner sums step, the blend steps on the single shared multiplier and the output
// load; the next transaction can be taken once the sequencer returns to idle after
// that output load
// reset (rst_n low, synchronous) clears the sequencer; the table is not cleared
// a finished result waits in the output register while the next transaction
// is taken; a stalled output holds the sequencer only at its last step
module gradient_noise_3d_with_derivatives_unit import gn3d_pkg::*; (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      in_valid,
  output logic                      in_ready,
  input  logic                      in_action,
  input  logic [IDX_W-1:0]          in_table_index,
  input  logic [7:0]                in_table_value,
  input  logic signed [COORD_W-1:0] in_coord_x,
  input  logic signed [COORD_W-1:0] in_coord_y,
  input  logic signed [COORD_W-1:0] in_coord_z,
  output logic                      out_valid,
  input  logic                      out_ready,
  output logic signed [OUT_W-1:0]   out_noise_value,
  output logic signed [OUT_W-1:0]   out_deriv_x,
  output logic signed [OUT_W-1:0]   out_deriv_y,
  output logic signed [OUT_W-1:0]   out_deriv_z
);

  gn3d_cmd_t cmd;

  // sequencer: hash walk, multiplier steps, output handshake
  gn3d_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_action (in_action),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .cmd       (cmd)
  );

  // datapath: table memory, dot products, shared multiplier, result registers
  gn3d_dp u_dp (
    .clk             (clk),
    .rst_n           (rst_n),
    .cmd             (cmd),
    .in_table_index  (in_table_index),
    .in_table_value  (in_table_value),
    .in_coord_x      (in_coord_x),
    .in_coord_y      (in_coord_y),
    .in_coord_z      (in_coord_z),
    .out_noise_value (out_noise_value),
    .out_deriv_x     (out_deriv_x),
    .out_deriv_y     (out_deriv_y),
    .out_deriv_z     (out_deriv_z)
  );

endmodule

/* rtl/core/gn3d_chk.sv */
// gn3d_chk: port level checks for the 3d gradient noise unit, bound to the top.
// Depends on gn3d_pkg.
module gn3d_chk import gn3d_pkg::*; (
  input logic                      clk,
  input logic                      rst_n,
  input logic                      in_valid,
  input logic                      in_ready,
  input logic                      in_action,
  input logic [IDX_W-1:0]          in_table_index,
  input logic [7:0]                in_table_value,
  input logic signed [COORD_W-1:0] in_coord_x,
  input logic signed [COORD_W-1:0] in_coord_y,
  input logic signed [COORD_W-1:0] in_coord_z,
  input logic                      out_valid,
  input logic                      out_ready,
  input logic signed [OUT_W-1:0]   out_noise_value,
  input logic signed [OUT_W-1:0]   out_deriv_x,
  input logic signed [OUT_W-1:0]   out_deriv_y,
  input logic signed [OUT_W-1:0]   out_deriv_z
);

  // stalled result stays valid and keeps its noise value and z derivative
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_noise_value) &&
    $stable(out_deriv_z))
    else $error("stalled result changed");

  // an evaluate transaction keeps the unit busy
  a_eval_busy: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready && in_action |=> !in_ready ##1 !in_ready)
    else $error("unit ready right after evaluate");

  // a load transaction leaves the unit ready
  a_load_ready: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready && !in_action |=> in_ready)
    else $error("unit busy after load");

  // a new result only appears out of a busy cycle
  a_out_from_busy: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid) |-> $past(!in_ready))
    else $error("result without evaluate");

endmodule

bind gradient_noise_3d_with_derivatives_unit gn3d_chk u_chk (.*);

/* bench/tb_gradient_noise_3d_with_derivatives_unit.sv */
// testbench for the 3d gradient noise unit: fills the permutation table,
// runs directed and random points and checks every result against a predictor
// depends on gn3d_pkg and gradient_noise_3d_with_derivatives_unit
module tb_gradient_noise_3d_with_derivatives_unit;
  import gn3d_pkg::*;

  localparam int WATCHDOG_LIMIT = 4000;   // idle cycles allowed with no transaction
  localparam int DRAIN_CYCLES   = 80;     // extra cycles run after the last result is checked

  typedef struct packed {
    logic signed [OUT_W-1:0] noise;
    logic signed [OUT_W-1:0] dx;
    logic signed [OUT_W-1:0] dy;
    logic signed [OUT_W-1:0] dz;
  } noise_result_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_ready;
  logic in_action = 1'b0;
  logic [IDX_W-1:0] in_table_index = '0;
  logic [7:0] in_table_value = '0;
  logic signed [COORD_W-1:0] in_coord_x = '0;
  logic signed [COORD_W-1:0] in_coord_y = '0;
  logic signed [COORD_W-1:0] in_coord_z = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  logic signed [OUT_W-1:0] out_noise_value, out_deriv_x, out_deriv_y, out_deriv_z;

  gradient_noise_3d_with_derivatives_unit dut (.*);

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // predictor state: our own copy of the permutation table
  logic [7:0] perm_copy [TABLE_SIZE];
  noise_result_t pending_results [$];
  int mismatches = 0;
  bit calm = 1'b0;     // when set, neither side idles

  function automatic int draw_gap();
    return calm ? 0 : $urandom_range(0, 12);
  endfunction

  // fixed point product, rounded half toward plus infinity
  function automatic longint fixmul(longint a, longint b);
    return (a * b + HALF_LSB) >>> FRAC_BITS;
  endfunction

  function automatic longint fade_curve(longint t);
    longint t2, t3, q;
    t2 = fixmul(t, t);
    t3 = fixmul(t2, t);
    q  = fixmul(t, 6 * t - 15 * (64'sd1 <<< FRAC_BITS)) + 10 * (64'sd1 <<< FRAC_BITS);
    return fixmul(t3, q);
  endfunction

  function automatic longint fade_slope(longint t);
    longint p;
    p = fixmul(t, t - (64'sd1 <<< FRAC_BITS));
    return 30 * fixmul(p, p);
  endfunction

  function automatic int lattice_hash(int xi, int yi, int zi);
    int h;
    h = int'(perm_copy[xi % TABLE_SIZE]);
    h = int'(perm_copy[(h + yi) % TABLE_SIZE]);
    h = int'(perm_copy[(h + zi) % TABLE_SIZE]);
    return h & 15;
  endfunction

  // dot of the hashed gradient with the corner offset
  function automatic longint gradient_dot(int g, longint x, longint y, longint z);
    case (g)
      0:  return x + y;
      1:  return -x + y;
      2:  return x - y;
      3:  return -x - y;
      4:  return x + z;
      5:  return -x + z;
      6:  return x - z;
      7:  return -x - z;
      8:  return y + z;
      9:  return -y + z;
      10: return y - z;
      11: return -y - z;
      12: return y + x;
      13: return -x + y;
      14: return -y + z;
      default: return -y - z;
    endcase
  endfunction

  function automatic logic signed [OUT_W-1:0] clamp_out(longint v);
    if (v > 524287) v = 524287;
    if (v < -524288) v = -524288;
    return v[OUT_W-1:0];
  endfunction

  function automatic noise_result_t predict_noise(logic [31:0] cx, logic [31:0] cy,
                                                  logic [31:0] cz);
    longint one, tx, ty, tz, x1, y1, z1, u, v, w, du, dv, dw;
    longint a, b, c, d, e, f, g, h, k1, k2, k3, k4, k5, k6, k7, uv, uw, vw, uvw;
    int x0, y0, z0, xn, yn, zn;
    noise_result_t r;
    one = 64'sd1 <<< FRAC_BITS;
    x0 = int'(cx[FRAC_BITS +: IDX_W]);
    y0 = int'(cy[FRAC_BITS +: IDX_W]);
    z0 = int'(cz[FRAC_BITS +: IDX_W]);
    xn = (x0 + 1) % TABLE_SIZE;
    yn = (y0 + 1) % TABLE_SIZE;
    zn = (z0 + 1) % TABLE_SIZE;
    tx = longint'(cx[FRAC_BITS-1:0]);
    ty = longint'(cy[FRAC_BITS-1:0]);
    tz = longint'(cz[FRAC_BITS-1:0]);
    x1 = tx - one;
    y1 = ty - one;
    z1 = tz - one;
    u = fade_curve(tx); v = fade_curve(ty); w = fade_curve(tz);
    du = fade_slope(tx); dv = fade_slope(ty); dw = fade_slope(tz);
    a = gradient_dot(lattice_hash(x0, y0, z0), tx, ty, tz);
    b = gradient_dot(lattice_hash(xn, y0, z0), x1, ty, tz);
    c = gradient_dot(lattice_hash(x0, yn, z0), tx, y1, tz);
    d = gradient_dot(lattice_hash(xn, yn, z0), x1, y1, tz);
    e = gradient_dot(lattice_hash(x0, y0, zn), tx, ty, z1);
    f = gradient_dot(lattice_hash(xn, y0, zn), x1, ty, z1);
    g = gradient_dot(lattice_hash(x0, yn, zn), tx, y1, z1);
    h = gradient_dot(lattice_hash(xn, yn, zn), x1, y1, z1);
    k1 = b - a;
    k2 = c - a;
    k3 = e - a;
    k4 = a + d - b - c;
    k5 = a + f - b - e;
    k6 = a + g - c - e;
    k7 = b + c + e + h - a - d - f - g;
    uv = fixmul(u, v);
    uw = fixmul(u, w);
    vw = fixmul(v, w);
    uvw = fixmul(uv, w);
    r.noise = clamp_out(a + fixmul(k1, u) + fixmul(k2, v) + fixmul(k3, w) + fixmul(k4, uv)
                        + fixmul(k5, uw) + fixmul(k6, vw) + fixmul(k7, uvw));
    r.dx = clamp_out(fixmul(du, k1 + fixmul(k4, v) + fixmul(k5, w) + fixmul(k7, vw)));
    r.dy = clamp_out(fixmul(dv, k2 + fixmul(k4, u) + fixmul(k6, w) + fixmul(k7, uw)));
    r.dz = clamp_out(fixmul(dw, k3 + fixmul(k5, u) + fixmul(k6, v) + fixmul(k7, uv)));
    return r;
  endfunction

  // one input transaction; valid drops only when a gap follows
  task automatic send_item(bit act, logic [7:0] idx, logic [7:0] val,
                           logic [31:0] x, logic [31:0] y, logic [31:0] z);
    int gap;
    gap = draw_gap();
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_action <= act;
    in_table_index <= idx;
    in_table_value <= val;
    in_coord_x <= x;
    in_coord_y <= y;
    in_coord_z <= z;
    do @(posedge clk); while (!in_ready);
    if (act) pending_results.push_back(predict_noise(x, y, z));
    else perm_copy[idx] = val;
  endtask

  task automatic send_load(logic [7:0] idx, logic [7:0] val);
    send_item(1'b0, idx, val, $urandom, $urandom, $urandom);
  endtask

  task automatic send_point(logic [31:0] x, logic [31:0] y, logic [31:0] z);
    send_item(1'b1, 8'($urandom), 8'($urandom), x, y, z);
  endtask

  // result side: random stall per transaction, compare with oldest prediction
  initial begin
    noise_result_t want;
    int stall;
    forever begin
      stall = draw_gap();
      if (stall > 0) begin
        out_ready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      out_ready <= 1'b1;
      do @(posedge clk); while (!(out_valid && rst_n));
      if (pending_results.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected result transaction");
      end else begin
        want = pending_results.pop_front();
        if (want.noise !== out_noise_value || want.dx !== out_deriv_x ||
            want.dy !== out_deriv_y || want.dz !== out_deriv_z) begin
          mismatches++;
          if (mismatches <= 10)
            $display("mismatch exp n=%0d dx=%0d dy=%0d dz=%0d got n=%0d dx=%0d dy=%0d dz=%0d",
                     want.noise, want.dx, want.dy, want.dz, out_noise_value,
                     out_deriv_x, out_deriv_y, out_deriv_z);
        end
      end
    end
  end

  // watchdog on cycles with no transaction on either channel
  int idle_cycles = 0;
  always @(posedge clk) begin
    if ((in_valid && in_ready) || (out_valid && out_ready)) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("TB_ERROR");
      $finish;
    end
  end

  // every entry is written before any point is evaluated
  task automatic test_table_fill();
    logic [7:0] shuffle [TABLE_SIZE];
    logic [7:0] tmp;
    int j;
    for (int i = 0; i < TABLE_SIZE; i++) shuffle[i] = 8'(i);
    for (int i = TABLE_SIZE - 1; i > 0; i--) begin
      j = $urandom_range(0, i);
      tmp = shuffle[i];
      shuffle[i] = shuffle[j];
      shuffle[j] = tmp;
    end
    for (int i = 0; i < TABLE_SIZE; i++) send_load(8'(i), shuffle[i]);
  endtask

  // extremes, negative floors, half fractions and the table wrap
  task automatic test_directed_points();
    send_point(32'h0, 32'h0, 32'h0);
    send_point(32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF);
    send_point(32'h8000_0000, 32'h8000_0000, 32'h8000_0000);
    send_point(32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
    send_point(32'h0000_8000, 32'h0000_8000, 32'h0000_8000);
    send_point(32'h00FF_FFFF, 32'h00FF_0001, 32'h00FF_8000);
    send_point(32'hFFFF_8000, 32'h0001_0000, 32'hFFFE_4000);
    send_point(32'h7FFF_0000, 32'h8000_FFFF, 32'h0000_0001);
    send_point(32'h0000_FFFF, 32'h0000_0000, 32'hFFFF_0000);
    send_point(32'h1234_5678, 32'hEDCB_A987, 32'h00FF_C000);
    // rewrite extreme entries with extreme bytes, then read across them
    send_load(8'hFF, 8'h00);
    send_load(8'h00, 8'hFF);
    send_point(32'h00FF_4000, 32'h00FF_C000, 32'h00FF_2000);
    send_point(32'h0000_4000, 32'hFFFF_C000, 32'h0000_2000);
  endtask

  function automatic logic [31:0] random_coord();
    case ($urandom_range(0, 3))
      0: return $urandom;
      1: return $signed($urandom_range(0, 32'h000F_FFFF)) - 32'sh0008_0000;
      2: return {8'($urandom), 8'($urandom_range(0, 1) ? 8'hFF : 8'h00), 16'($urandom)};
      default: return {$urandom_range(0, 1) ? 16'hFFFF : 16'h0000, 16'($urandom)};
    endcase
  endfunction

  // mostly points, some table rewrites, with idle stretches switched on and off
  task automatic test_random_mix();
    for (int i = 0; i < 1380; i++) begin
      if (i % 150 == 0) calm = ($urandom_range(0, 2) == 0);
      if ($urandom_range(0, 9) == 0) send_load(8'($urandom), 8'($urandom));
      else send_point(random_coord(), random_coord(), random_coord());
    end
    calm = 1'b0;
  endtask

  initial begin
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_table_fill();
    test_directed_points();
    test_random_mix();
    in_valid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (mismatches == 0) $display("TB_OK");
    else $display("TB_ERROR");
    $finish;
  end

endmodule

/* gradient_noise_3d_with_derivatives_unit.f */
rtl/core/gn3d_pkg.sv
rtl/core/gn3d_ctrl.sv
rtl/core/gn3d_dp.sv
rtl/core/gradient_noise_3d_with_derivatives_unit.sv
rtl/core/gn3d_chk.sv
bench/tb_gradient_noise_3d_with_derivatives_unit.sv
